// ----- rtl/rebd_pkg.sv -----
`default_nettype none
package rebd_pkg;

  typedef enum logic [2:0] {
    OP_CLOCK_EDGE  = 3'd0,
    OP_BUTTON_EDGE = 3'd1,
    OP_TAKE_LONG   = 3'd2,
    OP_TAKE_CHANGE = 3'd3,
    OP_TAKE_PRESS  = 3'd4
  } op_t;

  localparam int OP_WIDTH   = 3;
  localparam int TIME_WIDTH = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int POS_OUT_WIDTH = 16;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROTATE_LOCKOUT  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BUTTON_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS      = 2'd2;

  localparam logic [CFG_WIDTH-1:0] ROTATE_LOCKOUT_RST  = 16'd250;
  localparam logic [CFG_WIDTH-1:0] BUTTON_DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST      = 16'd320;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] rotate_lockout_ms;
    logic [CFG_WIDTH-1:0] button_debounce_ms;
    logic [CFG_WIDTH-1:0] long_press_ms;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/rebd_cfg_regs.sv -----
`default_nettype none
module rebd_cfg_regs
  import rebd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [CFG_IDX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_WIDTH-1:0]     wr_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_ROTATE_LOCKOUT:  cfg_nxt.rotate_lockout_ms  = wr_data;
        CFG_BUTTON_DEBOUNCE: cfg_nxt.button_debounce_ms = wr_data;
        CFG_LONG_PRESS:      cfg_nxt.long_press_ms      = wr_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_lockout_ms  <= ROTATE_LOCKOUT_RST;
      cfg_r.button_debounce_ms <= BUTTON_DEBOUNCE_RST;
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/rebd_core.sv -----
`default_nettype none
module rebd_core
  import rebd_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic [OP_WIDTH-1:0]       op,
  input  wire logic [TIME_WIDTH-1:0]     now_ms,
  input  wire logic                      data_level,
  input  wire cfg_t                      cfg,
  output logic                           taken,
  output logic [POSITION_WIDTH-1:0]      position,
  output logic                           button_down
);

  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      changed_r, changed_nxt;
  logic                      pressed_r, pressed_nxt;
  logic                      press_r, press_nxt;
  logic                      long_r, long_nxt;
  logic [TIME_WIDTH-1:0]     rot_time_r, rot_time_nxt;
  logic [TIME_WIDTH-1:0]     btn_time_r, btn_time_nxt;

  logic [TIME_WIDTH-1:0] rot_dt;
  logic [TIME_WIDTH-1:0] btn_dt;
  logic                  rot_ok;
  logic                  btn_ok;
  logic                  held_long;

  // Elapsed times wrap modulo 2^32, so a plain subtract does the job.
  assign rot_dt    = now_ms - rot_time_r;
  assign btn_dt    = now_ms - btn_time_r;
  assign rot_ok    = rot_dt >= TIME_WIDTH'(cfg.rotate_lockout_ms);
  assign btn_ok    = btn_dt >= TIME_WIDTH'(cfg.button_debounce_ms);
  assign held_long = btn_dt >  TIME_WIDTH'(cfg.long_press_ms);

  always_comb begin
    pos_nxt      = pos_r;
    changed_nxt  = changed_r;
    pressed_nxt  = pressed_r;
    press_nxt    = press_r;
    long_nxt     = long_r;
    rot_time_nxt = rot_time_r;
    btn_time_nxt = btn_time_r;
    taken        = 1'b0;
    case (op)
      OP_CLOCK_EDGE: begin
        taken = 1'b1;
        if (rot_ok) begin
          rot_time_nxt = now_ms;
          pos_nxt      = data_level ? pos_r + 1'b1 : pos_r - 1'b1;
          changed_nxt  = 1'b1;
        end
      end
      OP_BUTTON_EDGE: begin
        taken = 1'b1;
        if (btn_ok) begin
          if (pressed_r && held_long) begin
            long_nxt = 1'b1;
          end
          btn_time_nxt = now_ms;
          pressed_nxt  = !pressed_r;
          if (pressed_r) begin
            press_nxt = 1'b1;
          end
        end
      end
      OP_TAKE_LONG: begin
        if (long_r) begin
          long_nxt  = 1'b0;
          press_nxt = 1'b0;
          taken     = 1'b1;
        end
      end
      OP_TAKE_CHANGE: begin
        if (changed_r) begin
          changed_nxt = 1'b0;
          taken       = 1'b1;
        end
      end
      OP_TAKE_PRESS: begin
        if (press_r) begin
          press_nxt = 1'b0;
          taken     = 1'b1;
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      changed_r  <= 1'b0;
      pressed_r  <= 1'b0;
      press_r    <= 1'b0;
      long_r     <= 1'b0;
      rot_time_r <= '0;
      btn_time_r <= '0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      changed_r  <= changed_nxt;
      pressed_r  <= pressed_nxt;
      press_r    <= press_nxt;
      long_r     <= long_nxt;
      rot_time_r <= rot_time_nxt;
      btn_time_r <= btn_time_nxt;
    end
  end

  assign position    = pos_nxt;
  assign button_down = pressed_nxt;

endmodule
`default_nettype wire

// ----- rtl/rotary_encoder_button_debouncer.sv -----
// Rotary encoder and push-button event debouncer.
// Path: an accepted beat waits in the input register; its result then moves to the
// output register (two register stages) once that is empty or out_stall is low.
// Throughput: one beat per cycle while out_stall is low; one subtract-compare update.
// Reset (rst_n, synchronous, active low) clears the position, flags and stored
// times and loads the default windows of 250, 50 and 320 ms.
`default_nettype none
module rotary_encoder_button_debouncer
  import rebd_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_WIDTH-1:0]      in_opcode,
  input  wire logic [TIME_WIDTH-1:0]    in_now_ms,
  input  wire logic                     in_data_level,

  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_taken,
  output logic signed [POS_OUT_WIDTH-1:0] out_position,
  output logic                          out_button_down,

  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  // Input register stage.
  logic                  s1_valid_r, s1_valid_nxt;
  logic [OP_WIDTH-1:0]   s1_op_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic                  s1_dlev_r;

  // Output register stage.
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_taken_r;
  logic [POS_OUT_WIDTH-1:0] out_pos_r;
  logic                     out_btn_r;

  logic in_accept;
  logic fire;

  cfg_t                      cfg;
  logic                      core_taken;
  logic [POSITION_WIDTH-1:0] core_pos;
  logic                      core_btn;

  // Always writable; the user must write only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  rebd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The item in the input register moves on whenever the output register is
  // empty or its beat is being taken. The state advances with that move.
  assign fire      = s1_valid_r && (!out_valid_r || !out_stall);
  // A new beat is taken whenever the input register is empty or emptying, so
  // the block can still take one beat while a finished result waits downstream.
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r   <= in_opcode;
      s1_now_r  <= in_now_ms;
      s1_dlev_r <= in_data_level;
    end
  end

  rebd_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .op          (s1_op_r),
    .now_ms      (s1_now_r),
    .data_level  (s1_dlev_r),
    .cfg         (cfg),
    .taken       (core_taken),
    .position    (core_pos),
    .button_down (core_btn)
  );

  // The position is sign-extended from its own width, or cut, to 16 bits.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_taken_r <= core_taken;
      out_pos_r   <= POS_OUT_WIDTH'($signed(core_pos));
      out_btn_r   <= core_btn;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_taken       = out_taken_r;
  assign out_position    = $signed(out_pos_r);
  assign out_button_down = out_btn_r;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rebd_pkg::*;

  localparam int POS_W = 16;

  // Watchdog limit in clock cycles.
  localparam int CYCLE_LIMIT = 400000;

  // Cycles to let pass once the last expected result is in. The block has two
  // register stages, so this is comfortably more than it needs.
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 10;

  // Opcodes the block does not define. They must leave every flag alone.
  localparam logic [OP_WIDTH-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_RSVD_7 = 3'd7;

  // Index 3 has no register behind it. A write there must change nothing.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE = 2'd3;

  localparam int IDLE_PCT = 34;

  typedef struct packed {
    logic                            taken;
    logic signed [POS_OUT_WIDTH-1:0] position;
    logic                            button_down;
  } beat_result_t;

  typedef struct {
    logic [OP_WIDTH-1:0]   op;
    logic [TIME_WIDTH-1:0] now;
    logic                  dlev;
    bit                    typed;
    beat_result_t          want;
  } stim_row_t;

  typedef struct {
    logic [CFG_IDX_WIDTH-1:0] idx;
    logic [CFG_WIDTH-1:0]     data;
  } reg_write_t;

  // Clock and DUT inputs. Every input has a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic [OP_WIDTH-1:0]      in_opcode = OP_TAKE_CHANGE;
  logic [TIME_WIDTH-1:0]    in_now_ms = '0;
  logic                     in_data_level = 1'b0;
  logic                     out_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = CFG_ROTATE_LOCKOUT;
  logic [CFG_WIDTH-1:0]     cfg_data = '0;

  logic                            in_stall;
  logic                            out_valid;
  logic                            out_taken;
  logic signed [POS_OUT_WIDTH-1:0] out_position;
  logic                            out_button_down;
  logic                            cfg_ready;

  // Sideband that travels with the payload: a directed row may carry its own
  // hand-written expectation instead of the predicted one.
  logic         row_typed = 1'b0;
  beat_result_t row_want = '0;

  // Idling controls. calm turns off random idling on both sides. hold_go starts
  // a long receiver hold-off, which its own process times.
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_on = 1'b0;

  always #6 clk = ~clk;

  rotary_encoder_button_debouncer #(
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_now_ms      (in_now_ms),
    .in_data_level  (in_data_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_taken      (out_taken),
    .out_position   (out_position),
    .out_button_down(out_button_down),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors what the block holds after reset: zero position,
  // all flags clear, both stored times at zero and the default windows.
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0]  lockout_win  = ROTATE_LOCKOUT_RST;
  logic [CFG_WIDTH-1:0]  debounce_win = BUTTON_DEBOUNCE_RST;
  logic [CFG_WIDTH-1:0]  hold_win     = LONG_PRESS_RST;

  logic [POS_W-1:0]      pos_count   = '0;
  logic                  pos_changed = 1'b0;
  logic                  last_level  = 1'b0;
  logic                  btn_down    = 1'b0;
  logic                  press_seen  = 1'b0;
  logic                  long_seen   = 1'b0;
  logic [TIME_WIDTH-1:0] rot_time    = '0;
  logic [TIME_WIDTH-1:0] btn_time    = '0;

  beat_result_t results_due[$];
  reg_write_t   cfg_writes[$];
  stim_row_t    directed_rows[$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int beats_sent     = 0;
  int results_seen   = 0;
  int settings_used  = 0;

  // The counter is sign-extended from the counter width and then cut to the
  // width of the output port.
  function automatic logic signed [POS_OUT_WIDTH-1:0] position_view();
    return POS_OUT_WIDTH'($signed(pos_count));
  endfunction

  // Applies one event to the predictor state and returns the result it causes.
  // Elapsed times are plain 32-bit differences, so they wrap with the clock.
  function automatic beat_result_t debounce_step(input logic [OP_WIDTH-1:0] op,
                                                 input logic [TIME_WIDTH-1:0] now,
                                                 input logic dlev);
    beat_result_t r;
    logic [TIME_WIDTH-1:0] dt;
    r.taken = 1'b0;
    case (op)
      OP_CLOCK_EDGE: begin
        dt = now - rot_time;
        r.taken = 1'b1;
        if (dt >= {16'd0, lockout_win}) begin
          rot_time    = now;
          pos_count   = dlev ? pos_count + 1'b1 : pos_count - 1'b1;
          pos_changed = 1'b1;
          last_level  = dlev;
        end
      end
      OP_BUTTON_EDGE: begin
        dt = now - btn_time;
        r.taken = 1'b1;
        if (dt >= {16'd0, debounce_win}) begin
          // Only a release can be long: the hold time is measured from the press.
          if (btn_down && dt > {16'd0, hold_win}) long_seen = 1'b1;
          btn_time = now;
          btn_down = ~btn_down;
          if (!btn_down) press_seen = 1'b1;
        end
      end
      OP_TAKE_LONG: begin
        if (long_seen) begin
          long_seen  = 1'b0;
          press_seen = 1'b0;
          r.taken    = 1'b1;
        end
      end
      OP_TAKE_CHANGE: begin
        if (pos_changed) begin
          pos_changed = 1'b0;
          r.taken     = 1'b1;
        end
      end
      OP_TAKE_PRESS: begin
        if (press_seen) begin
          press_seen = 1'b0;
          r.taken    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.position    = position_view();
    r.button_down = btn_down;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 40)
      $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results still due",
             cycle_count, results_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge. An input beat is
  // predicted before any output beat of the same edge is checked, so the check
  // holds whatever the block's latency turns out to be.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    beat_result_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROTATE_LOCKOUT:  lockout_win  = cfg_data;
          CFG_BUTTON_DEBOUNCE: debounce_win = cfg_data;
          CFG_LONG_PRESS:      hold_win     = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        due = debounce_step(in_opcode, in_now_ms, in_data_level);
        if (row_typed) due = row_want;
        results_due.push_back(due);
        beats_sent++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          flag_mismatch("unexpected result beat", 32'(out_position), '0);
        end else begin
          due = results_due.pop_front();
          if (out_taken !== due.taken)
            flag_mismatch("taken", 32'(out_taken), 32'(due.taken));
          if (out_position !== due.position)
            flag_mismatch("position", 32'(out_position), 32'(due.position));
          if (out_button_down !== due.button_down)
            flag_mismatch("button_down", 32'(out_button_down), 32'(due.button_down));
        end
      end
    end
  end

  // Receiver side. It stalls at random unless the run is in a calm stretch, and
  // stalls without a break while a hold-off is running.
  always @(negedge clk) begin
    if (hold_on) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
  end

  // The hold-off is counted here, apart from the sender, so that the sender
  // keeps offering beats while the output is blocked and the block fills up.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (80) @(posedge clk);
    hold_on = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered at a falling edge and return at
  // a falling edge, so payload changes never meet a sampling edge.
  // ---------------------------------------------------------------------------

  // Offers one beat and returns at the falling edge after it was taken. Valid is
  // left high; the next beat or an explicit pause decides what it does next.
  task automatic send_beat(input logic [OP_WIDTH-1:0] op, input logic [TIME_WIDTH-1:0] now,
                           input logic dlev, input bit typed, input beat_result_t want);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_now_ms     <= now;
    in_data_level <= dlev;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the three windows back to back, and optionally pokes the unused
  // index with random data. Only called while the block is idle.
  task automatic apply_windows(input logic [CFG_WIDTH-1:0] lock, input logic [CFG_WIDTH-1:0] deb,
                               input logic [CFG_WIDTH-1:0] hold, input bit poke_spare);
    reg_write_t w;
    cfg_writes.push_back('{CFG_ROTATE_LOCKOUT, lock});
    if (poke_spare) cfg_writes.push_back('{CFG_SPARE, CFG_WIDTH'($urandom)});
    cfg_writes.push_back('{CFG_BUTTON_DEBOUNCE, deb});
    cfg_writes.push_back('{CFG_LONG_PRESS, hold});
    while (cfg_writes.size() != 0) begin
      w = cfg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Picks an elapsed time relative to a window: mostly close to it or on
  // either side of its boundary, sometimes zero, sometimes anything at all.
  function automatic logic [TIME_WIDTH-1:0] pick_gap(input logic [CFG_WIDTH-1:0] win);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    if (r <= 4) return {16'd0, win} + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 2 * win + 2);
  endfunction

  // Random events. Edge times are placed relative to the last accepted edge of
  // the same kind, so lockout, debounce and long-press boundaries are all hit
  // often, and the take opcodes find their flags set about as often as not.
  task automatic run_random(input int count);
    logic [OP_WIDTH-1:0]   op;
    logic [TIME_WIDTH-1:0] now;
    logic                  dlev;
    int unsigned           pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      dlev = 1'($urandom_range(0, 1));
      now  = $urandom;
      if (pick < 35) begin
        op  = OP_CLOCK_EDGE;
        now = rot_time + pick_gap(lockout_win);
      end else if (pick < 65) begin
        op  = OP_BUTTON_EDGE;
        now = btn_time + pick_gap((btn_down && $urandom_range(0, 1)) ? hold_win : debounce_win);
      end else if (pick < 75) begin
        op = OP_TAKE_LONG;
      end else if (pick < 85) begin
        op = OP_TAKE_CHANGE;
      end else if (pick < 95) begin
        op = OP_TAKE_PRESS;
      end else begin
        op = OP_WIDTH'($urandom_range(OP_RSVD_5, OP_RSVD_7));
      end
      send_beat(op, now, dlev, 1'b0, '0);
    end
  endtask

  task automatic add_row(input logic [OP_WIDTH-1:0] op, input logic [TIME_WIDTH-1:0] now,
                         input logic dlev, input bit typed, input beat_result_t want);
    directed_rows.push_back('{op, now, dlev, typed, want});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;

    // Synchronous reset, released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset windows of 250, 50 and 320 ms. Rows marked
    // as typed carry their expected result; the rest use the predictor.
    // Nothing is flagged after reset, so every take reports zero.
    add_row(OP_TAKE_CHANGE, 32'd0, 1'b0, 1, '{1'b0, 16'sd0, 1'b0});
    add_row(OP_TAKE_PRESS,  32'd0, 1'b0, 1, '{1'b0, 16'sd0, 1'b0});
    add_row(OP_TAKE_LONG,   32'd0, 1'b0, 1, '{1'b0, 16'sd0, 1'b0});
    // Windows start at time zero: an edge at 100 ms is locked out, one at
    // exactly 250 ms is the first that counts.
    add_row(OP_CLOCK_EDGE, 32'd100, 1'b1, 1, '{1'b1, 16'sd0, 1'b0});
    add_row(OP_CLOCK_EDGE, 32'd250, 1'b1, 1, '{1'b1, 16'sd1, 1'b0});
    add_row(OP_CLOCK_EDGE, 32'd499, 1'b0, 0, '0);
    add_row(OP_CLOCK_EDGE, 32'd500, 1'b0, 0, '0);
    // Stepping below zero wraps the position to all ones.
    add_row(OP_CLOCK_EDGE, 32'd750, 1'b0, 1, '{1'b1, -16'sd1, 1'b0});
    add_row(OP_TAKE_CHANGE, 32'd751, 1'b0, 0, '0);
    add_row(OP_TAKE_CHANGE, 32'd752, 1'b0, 0, '0);
    // Button: bounce inside the debounce window, then a release exactly at the
    // long-press time, which is still a short press.
    add_row(OP_BUTTON_EDGE, 32'd30,  1'b0, 0, '0);
    add_row(OP_BUTTON_EDGE, 32'd50,  1'b0, 0, '0);
    add_row(OP_BUTTON_EDGE, 32'd99,  1'b1, 0, '0);
    add_row(OP_BUTTON_EDGE, 32'd370, 1'b0, 0, '0);
    add_row(OP_TAKE_LONG,   32'd371, 1'b0, 0, '0);
    add_row(OP_TAKE_PRESS,  32'd372, 1'b0, 0, '0);
    // One millisecond past the long-press time: taking the long press also
    // clears the single press that the same release raised.
    add_row(OP_BUTTON_EDGE, 32'd1000, 1'b0, 0, '0);
    add_row(OP_BUTTON_EDGE, 32'd1321, 1'b1, 0, '0);
    add_row(OP_TAKE_LONG,   32'd1322, 1'b0, 0, '0);
    add_row(OP_TAKE_PRESS,  32'd1323, 1'b0, 0, '0);
    // Undefined opcodes change nothing and report zero.
    add_row(OP_RSVD_5, 32'hFFFF_FFFF, 1'b1, 1, '{1'b0, -16'sd1, 1'b0});
    add_row(OP_RSVD_7, 32'd0,         1'b0, 1, '{1'b0, -16'sd1, 1'b0});
    add_row(OP_RSVD_6, 32'h5555_AAAA, 1'b1, 0, '0);
    // The millisecond clock wraps: 249 after 0xFFFFFFFF is 250 ms later.
    add_row(OP_CLOCK_EDGE, 32'hFFFF_FFFF, 1'b1, 0, '0);
    add_row(OP_CLOCK_EDGE, 32'd249,       1'b1, 0, '0);
    add_row(OP_TAKE_CHANGE, 32'hAAAA_5555, 1'b0, 0, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.op, row.now, row.dlev, row.typed, row.want);
    end
    settle();

    // Zero windows: every edge counts and any release held over zero ms is long.
    apply_windows(16'd0, 16'd0, 16'd0, 0);
    run_random(220);
    settle();

    // Full-scale windows.
    apply_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    run_random(220);
    settle();

    // Moderate windows, no random idling on either side. Partway in the
    // receiver holds off for a long stretch while beats keep coming.
    apply_windows(CFG_WIDTH'($urandom_range(1, 400)), CFG_WIDTH'($urandom_range(1, 100)),
                  CFG_WIDTH'($urandom_range(1, 600)), 0);
    calm <= 1'b1;
    run_random(30);
    hold_go <= 1'b1;
    run_random(300);
    calm <= 1'b0;
    settle();

    // Tiny windows with a long-press time below the debounce time; the unused
    // register index gets a write as well.
    apply_windows(16'd1, 16'd1, 16'd0, 1);
    run_random(280);
    settle();

    // Fully random windows, with a full drain in the middle.
    apply_windows(CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), 0);
    run_random(150);
    settle();
    run_random(150);
    settle();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d event beats under %0d window settings, from zero to full scale,",
             beats_sent, settings_used);
    $display("with a long output hold-off and mid-run drains; %0d results compared, %0d bad.",
             results_seen, mismatch_count);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
